// File: design/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg: shared definitions for the 3x3 Laplacian sharpen block
// Payload types of the channels, register indexes, reset values and limits.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int HEIGHT_LIMIT     = 4096;

  localparam int SAMPLE_W    = 8;
  localparam int FWIDTH_W    = 12;
  localparam int FHEIGHT_W   = 13;
  localparam int CHCOUNT_W   = 3;
  localparam int ROW_W       = 12;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 12'd640;
  localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 13'd480;
  localparam logic [CHCOUNT_W-1:0] CHCOUNT_RESET = 3'd1;

  typedef struct packed {
    logic                action;
    logic [SAMPLE_W-1:0] sample;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                frame_end;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  wdata;
  } cfg_wr_t;

  // registered line store read data for one sample position
  typedef struct packed {
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] upper;
  } line_taps_t;

endpackage

// File: design/lps_chan_if.sv
// ----------------------------------------------------------------------------
// lps_chan_if: valid/ready channel
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lps_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/lps_line_store.sv
// ----------------------------------------------------------------------------
// lps_line_store: upper and middle line memories
// Middle line has two read ports (centre and right), upper line one.
// Read data is registered; reads see the contents before a same-edge write.
// ----------------------------------------------------------------------------
module lps_line_store
  import lps_pkg::*;
#(
  parameter int LINE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_CHANNELS,
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       rd_right_addr,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [SAMPLE_W-1:0] wr_sample,
  output line_taps_t          taps
);

  logic [SAMPLE_W-1:0] middle_line [LINE_DEPTH];
  logic [SAMPLE_W-1:0] upper_line  [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      middle_line[wr_addr] <= wr_sample;
      // old middle value at this position moves up one row
      upper_line[wr_addr]  <= taps.mid;
    end
    if (rd_en) begin
      taps.mid   <= middle_line[rd_addr];
      taps.right <= middle_line[rd_right_addr];
      taps.upper <= upper_line[rd_addr];
    end
  end

endmodule

// File: design/laplacian_sharpen_3x3_top.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_top: streaming 3x3 Laplacian sharpen
// Samples in raster order, channels interleaved; at most one result per sample.
// ----------------------------------------------------------------------------
// Channels: pixel_in takes {action, sample}; action 0 is a sample, 1 a flush
// tick. result_out gives {value, frame_end}. cfg writes frame_width (0),
// frame_height (1) and channel_count (2); a write to one of them restarts
// the stream at row 0 and drops pending results. cfg is always ready; write only when idle.
// Results trail the input by one row: samples of row r give the results of
// row r-1, and the last row is drained by flush ticks or by row 0 of the next
// frame. Row 0 samples with nothing pending give no result.
// Throughput: one item per clock while result_out is not stalled. The line
// store read and the compute stage load on the edge that accepts an item;
// the result register loads when the compute stage advances.
// Reset (rst, synchronous) clears counters, config to 640x480x1 and empties
// the pipeline; line store contents are not cleared.
// When result_out stalls, items pass the compute stage until one with a
// result waits there; pixel_in.ready then drops until the result register is taken.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top
  import lps_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  lps_chan_if.sink    pixel_in,
  lps_chan_if.source  result_out,
  lps_chan_if.sink    cfg
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int SW   = $clog2(LINE_DEPTH + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = (WW > FWIDTH_W) ? WW : FWIDTH_W;
  localparam int PX_W = $clog2(MAX_WIDTH);
  localparam int CH_W = $clog2(MAX_CHANNELS + 1);
  localparam int CI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // configuration
  logic [FWIDTH_W-1:0]  frame_width;
  logic [FHEIGHT_W-1:0] frame_height;
  logic [CHCOUNT_W-1:0] channel_count;

  logic [WW-1:0]        w;
  logic [FHEIGHT_W-1:0] h;
  logic [CH_W-1:0]      ch;
  logic [SW-1:0]        stride;
  logic [CW-1:0]        fw_ext;

  // input side counters
  logic [AW-1:0]   in_column;
  logic [PX_W-1:0] in_pixel;
  logic [CI_W-1:0] in_chan;
  logic [ROW_W-1:0] in_row;
  logic [SW-1:0]   out_position;

  // compute stage
  logic                s1_valid;
  logic                s1_result;
  logic                s1_compute;
  logic                s1_end;
  logic                s1_write;
  logic [AW-1:0]       s1_addr;
  logic [SAMPLE_W-1:0] s1_sample;

  logic [SAMPLE_W-1:0] middle_window [MAX_CHANNELS];

  line_taps_t taps;

  logic          in_fire, cfg_fire, cfg_restart, s1_adv, out_free;
  logic          is_flush, drain, interior, last_chan, row_end, last_row;
  logic [AW:0]   right_ext;
  logic [AW-1:0] right_addr;
  logic [11:0]   acc;
  logic [SAMPLE_W-1:0] left, sat;

  // clamp registers to their usable ranges
  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext < CW'(3)) w = WW'(3);
    else if (fw_ext > CW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else w = WW'(fw_ext);

    if (frame_height < 13'd3) h = 13'd3;
    else if (frame_height > 13'(HEIGHT_LIMIT)) h = 13'(HEIGHT_LIMIT);
    else h = frame_height;

    if (channel_count == 3'd0) ch = CH_W'(1);
    else if (channel_count > 3'(MAX_CHANNELS)) ch = CH_W'(MAX_CHANNELS);
    else ch = CH_W'(channel_count);
  end

  assign stride = SW'(w) * SW'(ch);

  assign in_fire  = pixel_in.valid && pixel_in.ready;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;

  // only writes to a known register restart the stream
  assign cfg_restart = cfg_fire && (cfg.payload.index == REG_FRAME_WIDTH
                                    || cfg.payload.index == REG_FRAME_HEIGHT
                                    || cfg.payload.index == REG_CHANNEL_COUNT);

  assign out_free = !result_out.valid || result_out.ready;
  assign s1_adv   = s1_valid && (!s1_result || out_free);
  assign pixel_in.ready = !s1_valid || s1_adv;

  assign is_flush  = pixel_in.payload.action;
  assign drain     = (is_flush || (in_row == '0)) && (out_position != '0);
  assign interior  = (in_pixel != '0) && (WW'(in_pixel) != w - WW'(1));
  assign last_chan = CH_W'(in_chan) == ch - CH_W'(1);
  assign row_end   = last_chan && (WW'(in_pixel) == w - WW'(1));
  assign last_row  = {1'b0, in_row} == h - 13'd1;

  // right neighbor; past the line end the value is never used
  assign right_ext  = {1'b0, in_column} + (AW+1)'(ch);
  assign right_addr = (right_ext >= (AW+1)'(LINE_DEPTH)) ? in_column : right_ext[AW-1:0];

  lps_line_store #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_line_store (
    .clk          (clk),
    .rd_en        (in_fire && !is_flush),
    .rd_addr      (in_column),
    .rd_right_addr(right_addr),
    .wr_en        (s1_adv && s1_write),
    .wr_addr      (s1_addr),
    .wr_sample    (s1_sample),
    .taps         (taps)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FWIDTH_RESET;
      frame_height  <= FHEIGHT_RESET;
      channel_count <= CHCOUNT_RESET;
      in_column     <= '0;
      in_pixel      <= '0;
      in_chan       <= '0;
      in_row        <= '0;
      out_position  <= '0;
    end else if (cfg_fire) begin
      case (cfg.payload.index)
        REG_FRAME_WIDTH:   frame_width   <= cfg.payload.wdata[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg.payload.wdata[FHEIGHT_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg.payload.wdata[CHCOUNT_W-1:0];
        default: ;
      endcase
      if (cfg.payload.index != REG_FRAME_WIDTH && cfg.payload.index != REG_FRAME_HEIGHT
          && cfg.payload.index != REG_CHANNEL_COUNT) begin
        // unknown register: no restart
      end else begin
        in_column    <= '0;
        in_pixel     <= '0;
        in_chan      <= '0;
        in_row       <= '0;
        out_position <= '0;
      end
    end else if (in_fire) begin
      if (drain) out_position <= out_position - SW'(1);
      if (!is_flush) begin
        if (row_end) begin
          in_column <= '0;
          in_pixel  <= '0;
          in_chan   <= '0;
          if (last_row) begin
            in_row       <= '0;
            out_position <= stride;
          end else begin
            in_row <= in_row + ROW_W'(1);
          end
        end else begin
          in_column <= in_column + AW'(1);
          if (last_chan) begin
            in_chan  <= '0;
            in_pixel <= in_pixel + PX_W'(1);
          end else begin
            in_chan <= in_chan + CI_W'(1);
          end
        end
      end
    end
  end

  // compute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_result  <= drain || (!is_flush && (in_row != '0));
      s1_compute <= !is_flush && (in_row > ROW_W'(1)) && interior;
      s1_end     <= drain && (out_position == SW'(1));
      s1_write   <= !is_flush;
      s1_addr    <= in_column;
      s1_sample  <= pixel_in.payload.sample;
    end
  end

  // last MAX_CHANNELS centre samples; the left neighbor sits ch-1 back
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      for (int k = 0; k < MAX_CHANNELS; k++) middle_window[k] <= '0;
    end else if (s1_adv && s1_write) begin
      for (int k = MAX_CHANNELS - 1; k > 0; k--) middle_window[k] <= middle_window[k-1];
      middle_window[0] <= taps.mid;
    end
  end

  assign left = middle_window[CI_W'(ch - CH_W'(1))];

  // 5*centre - four neighbors, range -1020..1275
  always_comb begin
    acc = {2'b00, taps.mid, 2'b00} + {4'b0000, taps.mid}
        - {4'b0000, left} - {4'b0000, taps.right}
        - {4'b0000, taps.upper} - {4'b0000, s1_sample};
    if (acc[11]) sat = '0;
    else if (acc[10:8] != 3'b000) sat = 8'hFF;
    else sat = acc[7:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (s1_adv && s1_result) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
    if (s1_adv && s1_result) begin
      result_out.payload.value     <= s1_compute ? sat : '0;
      result_out.payload.frame_end <= s1_end;
    end
  end

endmodule

// File: design/lps_checker.sv
// ----------------------------------------------------------------------------
// lps_checker: port-level checks for the Laplacian sharpen block
// Reset state, result hold under stall, backpressure source, drained ends.
// ----------------------------------------------------------------------------
module lps_checker
  import lps_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_value,
  input logic                out_frame_end
);

  // pipeline empties at reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_frame_end))
    else $error("stalled result changed");

  // input only stalls behind a result the receiver has not taken
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // the frame end marker comes from drained last-row results, all border
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_value == '0)
    else $error("frame end result not zero");

endmodule

bind laplacian_sharpen_3x3_top lps_checker u_lps_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (pixel_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .out_value    (result_out.payload.value),
  .out_frame_end(result_out.payload.frame_end)
);
